// ===== sv/lgb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lgb_pkg;

  // Line capacity in characters.
  localparam int LINE_MAX = 64;

  localparam int IDX_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam int CNT_W = $clog2(LINE_MAX + 1);
  localparam int CH_W  = 8;

  // Keystroke codes.
  localparam logic [CH_W-1:0] KEY_DEL   = 8'h2D;
  localparam logic [CH_W-1:0] KEY_LEFT  = 8'h3C;
  localparam logic [CH_W-1:0] KEY_RIGHT = 8'h3E;

  // Input command codes.
  localparam logic CMD_EDIT = 1'b0;
  localparam logic CMD_DUMP = 1'b1;

  // One port pair of a stack memory.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [CH_W-1:0]  wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

endpackage

`default_nettype wire

// ===== sv/line_edit_gap_buffer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  in_cmd (1), in_key (8)
// out_      output     out_valid/out_stall out_ch (8), out_last (1), out_empty_res (1)
//
// Insert and delete keystrokes complete in their accept state; cursor moves read one
// stack memory, then write the other through its single write port.
// A readout moves each character through a registered memory read, then a load of
// the output register, and waits while the output is stalled; an empty readout
// only loads the output register.
// Reset (rst_n low, synchronous) empties both stacks; memory contents are not cleared.
// The output register frees the editor from the result side: a keystroke is taken
// while the final readout transaction still waits on out_stall.

module line_edit_gap_buffer_top (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire                       in_cmd,
  input  wire  [lgb_pkg::CH_W-1:0]  in_key,
  output logic                      out_valid,
  input  wire                       out_stall,
  output logic [lgb_pkg::CH_W-1:0]  out_ch,
  output logic                      out_last,
  output logic                      out_empty_res
);
  import lgb_pkg::*;

  // Memory port requests from the sequencer, one per stack.
  ram_req_t        left_req;
  ram_req_t        right_req;
  logic [CH_W-1:0] left_rd;
  logic [CH_W-1:0] right_rd;

  // Characters before the cursor, bottom at address 0.
  lgb_ram u_left (
    .clk     (clk),
    .req     (left_req),
    .rd_data (left_rd)
  );

  // Characters after the cursor, top of stack nearest the cursor.
  lgb_ram u_right (
    .clk     (clk),
    .req     (right_req),
    .rd_data (right_rd)
  );

  // Sequencer: edit decode, cursor moves and the readout walk.
  lgb_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_key        (in_key),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ch        (out_ch),
    .out_last      (out_last),
    .out_empty_res (out_empty_res),
    .left_req      (left_req),
    .right_req     (right_req),
    .left_rd       (left_rd),
    .right_rd      (right_rd)
  );

endmodule

`default_nettype wire

// ===== sv/lgb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lgb_ram (
  input  wire                      clk,
  input  lgb_pkg::ram_req_t        req,
  output logic [lgb_pkg::CH_W-1:0] rd_data
);
  import lgb_pkg::*;

  logic [CH_W-1:0] mem_r [LINE_MAX];
  logic [CH_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem_r[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== sv/lgb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lgb_ctrl (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire                       in_cmd,
  input  wire  [lgb_pkg::CH_W-1:0]  in_key,
  output logic                      out_valid,
  input  wire                       out_stall,
  output logic [lgb_pkg::CH_W-1:0]  out_ch,
  output logic                      out_last,
  output logic                      out_empty_res,
  output lgb_pkg::ram_req_t         left_req,
  output lgb_pkg::ram_req_t         right_req,
  input  wire  [lgb_pkg::CH_W-1:0]  left_rd,
  input  wire  [lgb_pkg::CH_W-1:0]  right_rd
);
  import lgb_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MOVE = 2'd1;
  localparam logic [1:0] ST_DRD  = 2'd2;
  localparam logic [1:0] ST_DOUT = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] lc_r, lc_nxt;
  logic [CNT_W-1:0] rc_r, rc_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic             dir_r, dir_nxt;
  logic             src_r, src_nxt;
  logic             empty_r, empty_nxt;
  logic             ov_r, ov_nxt;
  logic [CH_W-1:0]  och_r, och_nxt;
  logic             olast_r, olast_nxt;
  logic             oempty_r, oempty_nxt;

  logic [CNT_W-1:0] total;
  logic [CNT_W-1:0] n_inc;
  logic [CNT_W-1:0] r_pos;
  logic             out_free;
  logic             is_last;

  assign total    = lc_r + rc_r;
  assign n_inc    = n_r + CNT_W'(1);
  assign r_pos    = total - n_inc;
  assign out_free = !ov_r || !out_stall;
  assign is_last  = empty_r || (n_inc == total);

  always_comb begin
    state_nxt  = state_r;
    lc_nxt     = lc_r;
    rc_nxt     = rc_r;
    n_nxt      = n_r;
    dir_nxt    = dir_r;
    src_nxt    = src_r;
    empty_nxt  = empty_r;
    ov_nxt     = ov_r && out_stall;
    och_nxt    = och_r;
    olast_nxt  = olast_r;
    oempty_nxt = oempty_r;
    left_req   = '0;
    right_req  = '0;
    in_stall   = (state_r != ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_DUMP) begin
            n_nxt     = '0;
            empty_nxt = (total == '0);
            state_nxt = (total == '0) ? ST_DOUT : ST_DRD;
          end else begin
            case (in_key)
              KEY_DEL: begin
                if (lc_r != '0) begin
                  lc_nxt = lc_r - CNT_W'(1);
                end
              end
              KEY_LEFT: begin
                if (lc_r != '0) begin
                  left_req.re    = 1'b1;
                  left_req.raddr = IDX_W'(lc_r - CNT_W'(1));
                  lc_nxt         = lc_r - CNT_W'(1);
                  dir_nxt        = 1'b0;
                  state_nxt      = ST_MOVE;
                end
              end
              KEY_RIGHT: begin
                if (rc_r != '0) begin
                  right_req.re    = 1'b1;
                  right_req.raddr = IDX_W'(rc_r - CNT_W'(1));
                  rc_nxt          = rc_r - CNT_W'(1);
                  dir_nxt         = 1'b1;
                  state_nxt       = ST_MOVE;
                end
              end
              default: begin
                if (total < CNT_W'(LINE_MAX)) begin
                  left_req.we    = 1'b1;
                  left_req.waddr = lc_r[IDX_W-1:0];
                  left_req.wdata = in_key;
                  lc_nxt         = lc_r + CNT_W'(1);
                end
              end
            endcase
          end
        end
      end
      ST_MOVE: begin
        if (dir_r) begin
          left_req.we    = 1'b1;
          left_req.waddr = lc_r[IDX_W-1:0];
          left_req.wdata = right_rd;
          lc_nxt         = lc_r + CNT_W'(1);
        end else begin
          right_req.we    = 1'b1;
          right_req.waddr = rc_r[IDX_W-1:0];
          right_req.wdata = left_rd;
          rc_nxt          = rc_r + CNT_W'(1);
        end
        state_nxt = ST_IDLE;
      end
      ST_DRD: begin
        if (n_r < lc_r) begin
          left_req.re    = 1'b1;
          left_req.raddr = n_r[IDX_W-1:0];
          src_nxt        = 1'b0;
        end else begin
          right_req.re    = 1'b1;
          right_req.raddr = r_pos[IDX_W-1:0];
          src_nxt         = 1'b1;
        end
        state_nxt = ST_DOUT;
      end
      ST_DOUT: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          och_nxt    = empty_r ? '0 : (src_r ? right_rd : left_rd);
          olast_nxt  = is_last;
          oempty_nxt = empty_r;
          if (is_last) begin
            lc_nxt    = '0;
            rc_nxt    = '0;
            state_nxt = ST_IDLE;
          end else begin
            n_nxt     = n_inc;
            state_nxt = ST_DRD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      lc_r    <= '0;
      rc_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lc_r    <= lc_nxt;
      rc_r    <= rc_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    dir_r    <= dir_nxt;
    src_r    <= src_nxt;
    empty_r  <= empty_nxt;
    och_r    <= och_nxt;
    olast_r  <= olast_nxt;
    oempty_r <= oempty_nxt;
  end

  assign out_valid     = ov_r;
  assign out_ch        = och_r;
  assign out_last      = olast_r;
  assign out_empty_res = oempty_r;

endmodule

`default_nettype wire
